### design/vde_pkg.sv
// Shared types and constants for the vector distance engine.
// No dependencies.
package vde_pkg;

    localparam int MAX_DIM    = 256;
    localparam int COORD_BITS = 16;
    localparam int CNT_W      = $clog2(MAX_DIM + 2);
    localparam int SSD_W      = 40;
    localparam int DOT_W      = 40;
    localparam int NORM_W     = 39;
    localparam int ROOT_W     = 20;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [1:0] METRIC_SQ_EUCLID = 2'd0;
    localparam logic [1:0] METRIC_EUCLID    = 2'd1;
    localparam logic [1:0] METRIC_COSINE    = 2'd2;

    // finished sums of one vector pair
    typedef struct packed {
        logic [SSD_W-1:0]         ssd;
        logic signed [DOT_W-1:0]  dot;
        logic [NORM_W-1:0]        norm_a;
        logic [NORM_W-1:0]        norm_b;
        logic                     sat;
    } t_entry;

endpackage

### design/vde_front.sv
// Front end: accepts coordinate pairs, multiplies, accumulates sums.
// Pushes the finished sums of a vector into the queue. Uses vde_pkg.
module vde_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [vde_pkg::COORD_BITS-1:0] i_coord_a,
    input  logic signed [vde_pkg::COORD_BITS-1:0] i_coord_b,
    input  logic                              i_last_element,
    output logic                              o_push,
    output vde_pkg::t_entry                   o_push_data
);
    import vde_pkg::*;

    logic                      r_s1_vld, r_s1_last, r_s1_en, r_s1_sat;
    logic [32:0]               r_p_ssd;
    logic signed [31:0]        r_p_dot;
    logic [30:0]               r_p_na, r_p_nb;
    logic [CNT_W-1:0]          r_cnt;
    logic [SSD_W-1:0]          r_ssd;
    logic signed [DOT_W-1:0]   r_dot;
    logic [NORM_W-1:0]         r_na, r_nb;

    logic signed [16:0]        diff;
    logic signed [33:0]        diff_sq;
    logic signed [31:0]        aa, bb;
    logic [SSD_W:0]            ssd_sum;
    logic signed [DOT_W:0]     dot_sum;
    logic [NORM_W:0]           na_sum, nb_sum;
    logic [SSD_W-1:0]          n_ssd;
    logic signed [DOT_W-1:0]   n_dot;
    logic [NORM_W-1:0]         n_na, n_nb;

    assign diff    = 17'(i_coord_a) - 17'(i_coord_b);
    assign diff_sq = diff * diff;
    assign aa      = i_coord_a * i_coord_a;
    assign bb      = i_coord_b * i_coord_b;

    always_comb begin
        ssd_sum = {1'b0, r_ssd} + {{(SSD_W-32){1'b0}}, r_p_ssd};
        dot_sum = {r_dot[DOT_W-1], r_dot} + {{(DOT_W-31){r_p_dot[31]}}, r_p_dot};
        na_sum  = {1'b0, r_na} + {{(NORM_W-30){1'b0}}, r_p_na};
        nb_sum  = {1'b0, r_nb} + {{(NORM_W-30){1'b0}}, r_p_nb};
        n_ssd = r_ssd;
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        if (r_s1_en) begin
            n_ssd = ssd_sum[SSD_W] ? '1 : ssd_sum[SSD_W-1:0];
            n_na  = na_sum[NORM_W] ? '1 : na_sum[NORM_W-1:0];
            n_nb  = nb_sum[NORM_W] ? '1 : nb_sum[NORM_W-1:0];
            if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
                n_dot = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                       : {1'b0, {(DOT_W-1){1'b1}}};
            else
                n_dot = dot_sum[DOT_W-1:0];
        end
    end

    assign o_push             = r_s1_vld & r_s1_last;
    assign o_push_data.ssd    = n_ssd;
    assign o_push_data.dot    = n_dot;
    assign o_push_data.norm_a = n_na;
    assign o_push_data.norm_b = n_nb;
    assign o_push_data.sat    = r_s1_sat;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p_ssd <= diff_sq[32:0];
            r_p_dot <= i_coord_a * i_coord_b;
            r_p_na  <= aa[30:0];
            r_p_nb  <= bb[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_last <= 1'b0;
            r_s1_en   <= 1'b0;
            r_s1_sat  <= 1'b0;
            r_cnt     <= '0;
            r_ssd     <= '0;
            r_dot     <= '0;
            r_na      <= '0;
            r_nb      <= '0;
        end else begin
            r_s1_vld <= i_accept;
            if (i_accept) begin
                r_s1_last <= i_last_element;
                r_s1_en   <= r_cnt < CNT_W'(MAX_DIM);
                r_s1_sat  <= r_cnt >= CNT_W'(MAX_DIM);
                if (i_last_element)
                    r_cnt <= '0;
                else if (r_cnt < CNT_W'(MAX_DIM))
                    r_cnt <= r_cnt + 1'b1;
                else
                    r_cnt <= CNT_W'(MAX_DIM + 1);
            end
            if (r_s1_vld) begin
                if (r_s1_last) begin
                    r_ssd <= '0;
                    r_dot <= '0;
                    r_na  <= '0;
                    r_nb  <= '0;
                end else begin
                    r_ssd <= n_ssd;
                    r_dot <= n_dot;
                    r_na  <= n_na;
                    r_nb  <= n_nb;
                end
            end
        end
    end

endmodule

### design/vde_fifo.sv
// Short queue of finished sums between front and back end.
// Uses vde_pkg.
module vde_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vde_pkg::t_entry i_push_data,
    input  logic            i_pop,
    output vde_pkg::t_entry o_pop_data,
    output logic            o_empty,
    output logic            o_almost_full
);
    import vde_pkg::*;

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_pop_data    = r_mem[r_rd];
    assign o_empty       = r_count == '0;
    // one slot kept free for the item still in the front pipeline
    assign o_almost_full = r_count >= (PTR_W+1)'(FIFO_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + 1'b1;
            if (i_pop)
                r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)
                r_count <= r_count + 1'b1;
            else if (!i_push && i_pop)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

### design/vde_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Uses vde_pkg.
module vde_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vde_pkg::SSD_W-1:0]   i_value,
    output logic                        o_done,
    output logic [vde_pkg::ROOT_W-1:0]  o_root
);
    import vde_pkg::*;

    localparam int REM_W = ROOT_W + 4;
    localparam int STEP_W = $clog2(ROOT_W);

    logic                r_busy, r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SSD_W-1:0]    r_val;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [REM_W-1:0]    rem_sh, trial;

    assign rem_sh = {r_rem[REM_W-3:0], r_val[SSD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SSD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### design/vde_back.sv
// Back end: takes finished sums from the queue and computes the metric.
// Uses vde_pkg and vde_sqrt.
module vde_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_metric,
    input  logic                        i_empty,
    input  vde_pkg::t_entry             i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [vde_pkg::SSD_W-1:0]   o_distance,
    output logic                        o_saturated
);
    import vde_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQA  = 6'b000010,
        S_SQB  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam logic [SSD_W-1:0] ONE_Q16 = SSD_W'(65536);

    t_state              r_state;
    t_entry              r_ent;
    logic [1:0]          r_metric;
    logic [ROOT_W-1:0]   r_ra;
    logic [SSD_W-1:0]    r_den;
    logic [SSD_W:0]      r_rem;
    logic [15:0]         r_q;
    logic [3:0]          r_qcnt;
    logic [SSD_W-1:0]    r_dist;
    logic                r_sat;

    logic                sq_start, sq_done;
    logic [SSD_W-1:0]    sq_value;
    logic [ROOT_W-1:0]   sq_root;
    logic [SSD_W-1:0]    mag;
    logic [SSD_W:0]      rem2;
    logic [15:0]         q_next;

    vde_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_valid     = r_state == S_OUT;
    assign o_distance  = r_dist;
    assign o_saturated = r_sat;

    assign mag    = r_ent.dot[DOT_W-1] ? SSD_W'(-r_ent.dot) : SSD_W'(r_ent.dot);
    assign rem2   = {r_rem[SSD_W-1:0], 1'b0};
    assign q_next = {r_q[14:0], rem2 >= {1'b0, r_den}};

    always_comb begin
        sq_start = 1'b0;
        sq_value = i_entry.ssd;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_metric == METRIC_EUCLID)
                        sq_start = 1'b1;
                    else if (i_metric == METRIC_COSINE &&
                             i_entry.norm_a != '0 && i_entry.norm_b != '0) begin
                        sq_start = 1'b1;
                        sq_value = SSD_W'(i_entry.norm_a);
                    end
                end
            end
            S_SQA: begin
                if (sq_done && r_metric == METRIC_COSINE) begin
                    sq_start = 1'b1;
                    sq_value = SSD_W'(r_ent.norm_b);
                end
            end
            S_SQB, S_MUL, S_DIV, S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_ent    <= i_entry;
                        r_metric <= i_metric;
                        r_sat    <= i_entry.sat;
                        if (sq_start) begin
                            r_state <= S_SQA;
                        end else begin
                            r_dist  <= (i_metric == METRIC_COSINE) ? ONE_Q16 : i_entry.ssd;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SQA: begin
                    if (sq_done) begin
                        if (r_metric == METRIC_COSINE) begin
                            r_ra    <= sq_root;
                            r_state <= S_SQB;
                        end else begin
                            r_dist  <= SSD_W'(sq_root);
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SQB: begin
                    if (sq_done) begin
                        r_den   <= r_ra * sq_root;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // ratio reaches one exactly when |dot| >= den
                    if (mag >= r_den) begin
                        r_dist  <= r_ent.dot[DOT_W-1] ? ONE_Q16 + ONE_Q16 : '0;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= {1'b0, mag};
                        r_q     <= '0;
                        r_qcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_q    <= q_next;
                    r_qcnt <= r_qcnt + 1'b1;
                    r_rem  <= q_next[0] ? rem2 - {1'b0, r_den} : rem2;
                    if (r_qcnt == 4'd15) begin
                        r_dist  <= r_ent.dot[DOT_W-1] ? ONE_Q16 + SSD_W'(q_next)
                                                      : ONE_Q16 - SSD_W'(q_next);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/vector_distance_engine.sv
// Top level of the vector distance engine: config register, front end,
// queue and back end. Uses vde_pkg, vde_front, vde_fifo, vde_back.
//
// Streams one signed Q8.8 coordinate pair per cycle while o_stall is low;
// the item flagged last closes the vector pair and yields one distance
// per metric_select (0 squared euclidean Q.16, 1 euclidean Q.8, 2 cosine
// distance Q.16). Accumulation runs at one item per cycle. The finishing
// math behind a four-entry queue is a direct output for squared
// euclidean, one root for euclidean, and two roots, a product and a
// 16-step divider for cosine (no divide when the ratio clamps at one),
// with the roots on the shared bit-serial square root; input stalls only
// when finished vectors back up the queue. Write metric_select only while idle.
module vector_distance_engine (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [vde_pkg::COORD_BITS-1:0] i_coord_a,
    input  logic signed [vde_pkg::COORD_BITS-1:0] i_coord_b,
    input  logic                                  i_last_element,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [vde_pkg::SSD_W-1:0]             o_distance,
    output logic                                  o_saturated
);
    import vde_pkg::*;

    logic [1:0] r_metric;
    logic       push, pop, empty, almost_full;
    t_entry     push_data, pop_data;

    assign o_stall = almost_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_metric <= METRIC_SQ_EUCLID;
        else if (i_cfg_we)
            r_metric <= i_cfg_data;
    end

    vde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (i_valid && !almost_full),
        .i_coord_a      (i_coord_a),
        .i_coord_b      (i_coord_b),
        .i_last_element (i_last_element),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    vde_fifo u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_push_data   (push_data),
        .i_pop         (pop),
        .o_pop_data    (pop_data),
        .o_empty       (empty),
        .o_almost_full (almost_full)
    );

    vde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_metric    (r_metric),
        .i_empty     (empty),
        .i_entry     (pop_data),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_distance  (o_distance),
        .o_saturated (o_saturated)
    );

endmodule
